// File: rtl/pob_pkg.sv
// ----------------------------------------------------------------------------
// pob_pkg
// Shared types, codes and waveform helper for the polyphonic oscillator bank.
// ----------------------------------------------------------------------------
package pob_pkg;

   // Default voice count
   localparam int VOICES_DEFAULT = 8;

   // Request kinds
   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

   // Waveform modes
   localparam logic [1:0] MODE_RAMP  = 2'd0;
   localparam logic [1:0] MODE_PULSE = 2'd1;
   localparam logic [1:0] MODE_TRI   = 2'd2;

   // Output gain 0.4 in Q15
   localparam int GAIN_Q15 = 13107;
   localparam int GAIN_W   = 15;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_TICK_ADD,
      ST_TICK_MIX,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Q1.15 waveform value for one phase
   function automatic logic signed [15:0] wave_value(input logic [1:0]  mode,
                                                    input logic [31:0] phase);
      logic        [15:0] h;
      logic signed [17:0] h2;
      logic signed [17:0] tri_v;
      logic signed [15:0] result;
      h      = phase[31:16];
      h2     = signed'({1'b0, h, 1'b0});
      tri_v  = '0;
      result = '0;
      case (mode)
         MODE_RAMP: begin
            result = signed'({~h[15], h[14:0]});
         end
         MODE_PULSE: begin
            result = (phase != 32'd0 && !phase[31]) ? 16'sh7fff : 16'sh8000;
         end
         MODE_TRI: begin
            if (h < 16'd16384) begin
               tri_v = h2;
            end else if (h < 16'd49152) begin
               tri_v = 18'sd65536 - h2;
            end else begin
               // 2h - 131072: set the sign bit over 2h
               tri_v = signed'({1'b1, h, 1'b0});
            end
            // Clip the positive peak
            if (tri_v > 18'sd32767) begin
               result = 16'sh7fff;
            end else begin
               result = tri_v[15:0];
            end
         end
         default: begin
            result = '0;
         end
      endcase
      return result;
   endfunction

endpackage

// File: rtl/polyphonic_oscillator_bank.sv
// Sequencing: note on/off scans the voice table one voice at a time, then claims
//   or frees a voice; a tick walks the table with one phase adder and one mixer
//   adder, one voice at a time, then applies the gain and hands the sample to the
//   output register; a result still held stalls the next.
// Throughput: one request at a time; req_ready is high only while the sequencer idles.
// Reset: synchronous, active high; clears all voices, phases and the waveform mode.
// ----------------------------------------------------------------------------
// polyphonic_oscillator_bank
// Voice table with phase accumulators, waveform lookup and scaled mix output.
// ----------------------------------------------------------------------------
module polyphonic_oscillator_bank
   import pob_pkg::*;
#(
   parameter int VOICES = VOICES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_key_id,
   input  logic [30:0]        req_phase_step,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_mix_sample,
   output logic [7:0]         rsp_active_mask,
   // Configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data
);

   localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SUM_W  = 17 + IDX_W;
   localparam int PROD_W = SUM_W + GAIN_W;
   localparam int MASK_W = (VOICES > 8) ? VOICES : 8;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

   // Voice table
   logic [VOICES-1:0] active_ff;
   logic [7:0]        key_ff   [VOICES];
   logic [30:0]       step_ff  [VOICES];
   logic [31:0]       phase_ff [VOICES];

   // Sequencer and request registers
   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [1:0]                kind_ff, kind_in;
   logic [7:0]                rkey_ff, rkey_in;
   logic [30:0]               rstep_ff, rstep_in;
   logic                      match_found_ff, match_found_in;
   logic [IDX_W-1:0]          match_idx_ff, match_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic                      voice_on_ff, voice_on_in;
   logic [31:0]               newp_ff, newp_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [1:0]                mode_ff, mode_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [17:0]        mix_ff, mix_in;
   logic [7:0]                mask_ff, mask_in;

   // Table write controls
   logic              phase_we;
   logic              slot_we;
   logic [IDX_W-1:0]  slot_idx;
   logic              active_set;
   logic              active_clr;
   logic [MASK_W-1:0] active_ext;
   logic signed [PROD_W-1:0] scaled;

   assign active_ext = MASK_W'(active_ff);
   assign scaled     = prod_ff >>> 15;

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      rkey_in        = rkey_ff;
      rstep_in       = rstep_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      voice_on_in    = voice_on_ff;
      newp_in        = newp_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      mode_in        = csr_write_enable ? csr_write_data : mode_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mix_in         = mix_ff;
      mask_in        = mask_ff;
      req_ready      = 1'b0;
      phase_we       = 1'b0;
      slot_we        = 1'b0;
      slot_idx       = '0;
      active_set     = 1'b0;
      active_clr     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in        = req_kind;
               rkey_in        = req_key_id;
               rstep_in       = req_phase_step;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               acc_in         = '0;
               if (req_kind == KIND_TICK) begin
                  state_in = ST_TICK_ADD;
               end else if (req_kind == KIND_NOTE_ON || req_kind == KIND_NOTE_OFF) begin
                  state_in = ST_SCAN;
               end
            end
         end

         // Walk the table for the first key match and first free slot
         ST_SCAN: begin
            if (active_ff[idx_ff] && key_ff[idx_ff] == rkey_ff && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = idx_ff;
            end
            if (!active_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_APPLY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Claim or free a voice
         ST_APPLY: begin
            if (kind_ff == KIND_NOTE_ON) begin
               slot_we    = 1'b1;
               active_set = 1'b1;
               if (match_found_ff) begin
                  slot_idx = match_idx_ff;
               end else if (free_found_ff) begin
                  slot_idx = free_idx_ff;
               end else begin
                  slot_idx = '0;
               end
            end else if (match_found_ff) begin
               active_clr = 1'b1;
               slot_idx   = match_idx_ff;
            end
            state_in = ST_IDLE;
         end

         // Advance one voice's phase
         ST_TICK_ADD: begin
            voice_on_in = active_ff[idx_ff];
            newp_in     = phase_ff[idx_ff] + {1'b0, step_ff[idx_ff]};
            phase_we    = active_ff[idx_ff];
            state_in    = ST_TICK_MIX;
         end

         // Mix that voice's waveform value
         ST_TICK_MIX: begin
            if (voice_on_ff) begin
               acc_in = acc_ff + SUM_W'(wave_value(mode_ff, newp_ff));
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCALE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TICK_ADD;
            end
         end

         // Apply the output gain
         ST_SCALE: begin
            prod_in  = PROD_W'(acc_ff) * PROD_W'(signed'(GAIN_W'(GAIN_Q15)));
            state_in = ST_OUT;
         end

         // Hand the sample to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               mix_in       = scaled[17:0];
               mask_in      = active_ext[7:0];
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         mode_ff      <= MODE_RAMP;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (active_set) begin
            active_ff[slot_idx] <= 1'b1;
         end else if (active_clr) begin
            active_ff[slot_idx] <= 1'b0;
         end
      end
   end

   // Phase accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            phase_ff[i] <= '0;
         end
      end else if (phase_we) begin
         phase_ff[idx_ff] <= newp_in;
      end
   end

   // Key and step slots
   always_ff @(posedge clock) begin
      if (slot_we) begin
         key_ff[slot_idx]  <= rkey_ff;
         step_ff[slot_idx] <= rstep_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      rkey_ff        <= rkey_in;
      rstep_ff       <= rstep_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      voice_on_ff    <= voice_on_in;
      newp_ff        <= newp_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      mix_ff         <= mix_in;
      mask_ff        <= mask_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mix_sample  = mix_ff;
   assign rsp_active_mask = mask_ff;

endmodule

// File: verif/tb_polyphonic_oscillator_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphonic_oscillator_bank
// Self-checking bench for the eight-voice oscillator bank. A short directed
// table covers voice allocation corner cases and every waveform mode, then
// random note-on, note-off and tick requests run under several waveform
// settings with random sender bursts and receiver stalls. Every tick result
// is checked against its typed row or a cycle-free model of the voice table kept here.
// ----------------------------------------------------------------------------
module tb_polyphonic_oscillator_bank;
   import pob_pkg::*;

   localparam int          NUM_VOICES      = VOICES_DEFAULT;
   localparam logic [1:0]  KIND_UNUSED     = 2'd3;
   localparam logic [1:0]  MODE_MUTE       = 2'd3;
   localparam longint      MIX_GAIN_Q15    = 13107;
   localparam int          SETTLE_CYCLES   = 2 * NUM_VOICES + 3 + 8;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          QUIET_LIMIT     = 4000;
   localparam int          PHASES          = 6;
   localparam int          ITEMS_PER_PHASE = 125;
   localparam int          REPORT_LIMIT    = 10;

   typedef struct packed {
      logic signed [17:0] mix;
      logic [7:0]         mask;
   } mix_result_type;

   // One directed row: a request, or a waveform register write when is_csr
   // is set (code then holds the mode). typed rows carry their own result.
   typedef struct packed {
      logic               is_csr;
      logic [1:0]         code;
      logic [7:0]         key;
      logic [30:0]        step;
      logic               typed;
      logic signed [17:0] mix;
      logic [7:0]         mask;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 29;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // tick with no voice playing
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b1, 18'sd0,      8'h00},
      // note-off with nothing to release, unused kind
      '{1'b0, KIND_NOTE_OFF, 8'd5,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_UNUSED,   8'd255, 31'h7fff_ffff,  1'b0, 18'sd0,      8'h00},
      // one voice parked at phase zero: saw and square both give full negative
      '{1'b0, KIND_NOTE_ON,  8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b1, -18'sd13107, 8'h01},
      '{1'b1, MODE_PULSE,    8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b1, -18'sd13107, 8'h01},
      '{1'b1, MODE_RAMP,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      // largest step, then re-strike of an active key with a new step
      '{1'b0, KIND_NOTE_ON,  8'd255, 31'h7fff_ffff,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd0,   31'h4000_0000,  1'b0, 18'sd0,      8'h00},
      // fill the remaining voices
      '{1'b0, KIND_NOTE_ON,  8'd1,   31'd1,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd2,   31'h2000_0000,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd3,   31'h1234_5678,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd4,   31'h5555_5555,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd5,   31'h2aaa_aaaa,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_ON,  8'd6,   31'h0001_0000,  1'b0, 18'sd0,      8'h00},
      // every voice busy: slot zero is stolen
      '{1'b0, KIND_NOTE_ON,  8'd200, 31'h4000_0000,  1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      // release a key twice, the second finds nothing
      '{1'b0, KIND_NOTE_OFF, 8'd255, 31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_NOTE_OFF, 8'd255, 31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b1, MODE_PULSE,    8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      // triangle: the stolen voice lands on zero, then on the clipped peak
      '{1'b1, MODE_TRI,      8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      // unused mode silences every voice
      '{1'b1, MODE_MUTE,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00},
      '{1'b0, KIND_TICK,     8'd0,   31'd0,          1'b1, 18'sd0,      8'hfd},
      '{1'b1, MODE_RAMP,     8'd0,   31'd0,          1'b0, 18'sd0,      8'h00}
   };

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind         = KIND_TICK;
   logic [7:0]         req_key_id       = '0;
   logic [30:0]        req_phase_step   = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic signed [17:0] rsp_mix_sample;
   logic [7:0]         rsp_active_mask;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_write_data   = MODE_RAMP;

   // Model of the voice table
   logic        voice_on  [NUM_VOICES];
   logic [7:0]  voice_key [NUM_VOICES];
   logic [30:0] voice_inc [NUM_VOICES];
   logic [31:0] voice_acc [NUM_VOICES];
   logic [1:0]  wave_sel;

   mix_result_type mix_expect_q[$];
   int unsigned mismatch_cnt  = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned burst_left    = 0;
   bit          long_hold_due = 1'b0;

   polyphonic_oscillator_bank u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_key_id       (req_key_id),
      .req_phase_step   (req_phase_step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mix_sample   (rsp_mix_sample),
      .rsp_active_mask  (rsp_active_mask),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Q1.15 level of one voice at the current waveform setting
   function automatic int voice_level(input logic [31:0] ph);
      int h;
      int v;
      h = int'(ph[31:16]);
      v = 0;
      case (wave_sel)
         MODE_RAMP: begin
            v = h - 32768;
         end
         MODE_PULSE: begin
            v = (ph != 32'd0 && ph < 32'h8000_0000) ? 32767 : -32768;
         end
         MODE_TRI: begin
            if (h < 16384) begin
               v = 2 * h;
            end else if (h < 49152) begin
               v = 65536 - 2 * h;
            end else begin
               v = 2 * h - 131072;
            end
            if (v > 32767) begin
               v = 32767;
            end
         end
         default: begin
            v = 0;
         end
      endcase
      return v;
   endfunction

   // Apply one accepted request to the model; ticks yield a mix result
   function automatic void play_request(input logic [1:0] kind, input logic [7:0] key,
                                        input logic [30:0] step, output bit has_mix,
                                        output mix_result_type res);
      int     slot;
      longint acc_sum;
      longint scaled;
      has_mix = 1'b0;
      res     = '0;
      slot    = -1;
      acc_sum = 0;
      case (kind)
         KIND_NOTE_ON: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (slot < 0 && voice_on[i] && voice_key[i] == key) begin
                  slot = i;
               end
            end
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (slot < 0 && !voice_on[i]) begin
                  slot = i;
               end
            end
            if (slot < 0) begin
               slot = 0;
            end
            voice_on[slot]  = 1'b1;
            voice_key[slot] = key;
            voice_inc[slot] = step;
         end
         KIND_NOTE_OFF: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (slot < 0 && voice_on[i] && voice_key[i] == key) begin
                  slot        = i;
                  voice_on[i] = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               if (voice_on[i]) begin
                  voice_acc[i] = voice_acc[i] + {1'b0, voice_inc[i]};
                  acc_sum += voice_level(voice_acc[i]);
                  if (i < 8) begin
                     res.mask[i] = 1'b1;
                  end
               end
            end
            // floor of sum * 0.4
            scaled  = (acc_sum * MIX_GAIN_Q15) >>> 15;
            res.mix = scaled[17:0];
            has_mix = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Offer one request, hold it until accepted, then predict its result
   task automatic send_request(input logic [1:0] kind, input logic [7:0] key,
                               input logic [30:0] step, input bit typed,
                               input mix_result_type typed_res);
      int unsigned    gap;
      bit             has_mix;
      mix_result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_key_id     <= key;
      req_phase_step <= step;
      do @(posedge clock); while (!req_ready);
      play_request(kind, key, step, has_mix, predicted);
      if (has_mix) begin
         mix_expect_q.push_back(typed ? typed_res : predicted);
      end
   endtask

   // Drop valid and wait until every result is back and the block is quiet
   task automatic settle_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (mix_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_waveform(input logic [1:0] mode);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wave_sel = mode;
   endtask

   // Stimulus: directed table, then random phases under varied waveforms
   initial begin : stimulus
      logic [1:0]     kind;
      logic [7:0]     key;
      logic [30:0]    step;
      int unsigned    pick;
      mix_result_type typed_res;
      for (int i = 0; i < NUM_VOICES; i++) begin
         voice_on[i]  = 1'b0;
         voice_key[i] = '0;
         voice_inc[i] = '0;
         voice_acc[i] = '0;
      end
      wave_sel = MODE_RAMP;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].is_csr) begin
            write_waveform(DIRECTED_ROWS[r].code);
         end else begin
            typed_res.mix  = DIRECTED_ROWS[r].mix;
            typed_res.mask = DIRECTED_ROWS[r].mask;
            send_request(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].key,
                         DIRECTED_ROWS[r].step, DIRECTED_ROWS[r].typed, typed_res);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       write_waveform(MODE_PULSE);
            1:       write_waveform(MODE_TRI);
            2:       write_waveform(MODE_RAMP);
            3:       write_waveform(MODE_MUTE);
            4:       write_waveform(MODE_TRI);
            default: write_waveform(2'($urandom_range(0, 3)));
         endcase
         // long receiver stall while requests keep coming
         if (phase == 2) begin
            long_hold_due = 1'b1;
         end
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               kind = KIND_TICK;
            end else if (pick < 70) begin
               kind = KIND_NOTE_ON;
            end else if (pick < 95) begin
               kind = KIND_NOTE_OFF;
            end else begin
               kind = KIND_UNUSED;
            end
            // a small key pool keeps re-strikes, releases and stealing frequent
            key = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 11));
            case ($urandom_range(0, 5))
               0:       step = '0;
               1:       step = '1;
               2:       step = 31'h4000_0000;
               3, 4:    step = 31'($urandom_range(1, 32'h0010_0000));
               default: step = 31'($urandom);
            endcase
            send_request(kind, key, step, 1'b0, '0);
         end
      end

      settle_idle();
      if (mix_expect_q.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", mix_expect_q.size()));
      end
      if (mismatch_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Receiver pacing: runs of always ready, random, sparse and toggling
   initial begin : rsp_pacing
      int unsigned style;
      int unsigned run_len;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            long_hold_due = 1'b0;
         end
         style   = $urandom_range(0, 3);
         run_len = $urandom_range(1, 60);
         repeat (run_len) begin
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
            @(posedge clock);
         end
      end
   end

   // Check each returned mix against the oldest prediction
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_expect_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result mix=%0d mask=%02h",
                                   rsp_mix_sample, rsp_active_mask));
         end else begin
            want = mix_expect_q.pop_front();
            if (rsp_mix_sample !== want.mix) begin
               log_mismatch($sformatf("mix_sample expected %0d got %0d",
                                      want.mix, rsp_mix_sample));
            end
            if (rsp_active_mask !== want.mask) begin
               log_mismatch($sformatf("active_mask expected %02h got %02h",
                                      want.mask, rsp_active_mask));
            end
         end
      end
   end

   // Watchdog: end the run when no request or result moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
